// ===== hdl/assert_macros.svh =====
// Assertion macros used by the RTL top level of the grouped pointwise convolution.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge, off while reset is asserted.
`define GPC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property at every rising edge, reset included.
`define GPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/gpc_pkg.sv =====
// Package of the grouped pointwise convolution: sizes, codes and helpers.
// No dependencies.
`default_nettype none

package gpc_pkg;

  localparam int MAX_GROUPS       = 8;
  localparam int MAX_CIN          = 16;
  localparam int MAX_COUT         = 64;
  localparam int MAX_LENGTH       = 4096;
  localparam int WEIGHT_DEPTH     = MAX_GROUPS * MAX_COUT * MAX_CIN;
  localparam int BIAS_DEPTH       = MAX_GROUPS * MAX_COUT;
  localparam int WADDR_W          = $clog2(WEIGHT_DEPTH);
  localparam int BADDR_W          = $clog2(BIAS_DEPTH);
  localparam int ACC_W            = 38;
  localparam int DST_W            = 21;

  localparam logic [1:0] OP_WEIGHT = 2'd0;
  localparam logic [1:0] OP_BIAS   = 2'd1;
  localparam logic [1:0] OP_SAMPLE = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] SEC_DT = 2'd0;
  localparam logic [1:0] SEC_B  = 2'd1;
  localparam logic [1:0] SEC_C  = 2'd2;

  localparam logic [2:0] REG_CPG  = 3'd0;
  localparam logic [2:0] REG_GRP  = 3'd1;
  localparam logic [2:0] REG_LEN  = 3'd2;
  localparam logic [2:0] REG_DT   = 3'd3;
  localparam logic [2:0] REG_ST   = 3'd4;
  localparam logic [2:0] REG_BIAS = 3'd5;

  // Clamp the accumulator to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(32'sh7FFF_FFFF);
    lo = -(ACC_W'(33'sh0_8000_0000));
    if (v > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (v < lo) begin
      return 32'sh8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== hdl/gpc_cell.sv =====
// One cell of the activation chain: holds one sample, loads from the input
// channel or takes its neighbor's sample on a shift. Uses gpc_pkg.
`default_nettype none

module gpc_cell
  import gpc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               load,
  input  wire logic signed [15:0] load_data,
  input  wire logic               shift,
  input  wire logic signed [15:0] nbr_data,
  output logic signed [15:0]      data
);

  logic signed [15:0] data_r;

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end else if (shift) begin
      data_r <= nbr_data;
    end
  end

  assign data = data_r;

endmodule

`default_nettype wire

// ===== hdl/grouped_pointwise_conv1d_split_out.sv =====
// Grouped pointwise convolution top level: config port, weight and bias
// memories, activation cell chain, MAC pipeline and result register.
// Depends on gpc_pkg, gpc_cell and assert_macros.svh.
//
// Weight writes, bias writes, stray and non-final activation elements are
// taken while idle without stalling the input. The element for the last
// channel of a group starts a run: the setup states ST_PREP1 to ST_PREP3
// form the index products, then each of the R+2N outputs takes
// channels_per_group weight reads (one read port on the weight memory, one
// sample per read from the rotating activation chain), pipeline stages s1
// and s2 to the result register, and the output transfer. The input stalls
// from the triggering transfer until the last output has been transferred;
// a stall on the output side lengthens the wait.
`default_nettype none
`include "assert_macros.svh"

module grouped_pointwise_conv1d_split_out
  import gpc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_operation,
  input  wire logic [12:0]        in_table_address,
  input  wire logic signed [31:0] in_table_value,
  input  wire logic [2:0]         in_group_index,
  input  wire logic [3:0]         in_channel_index,
  input  wire logic [11:0]        in_position,
  input  wire logic signed [15:0] in_sample_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      out_result_value,
  output logic [20:0]             out_destination_index,
  output logic [1:0]              out_section,
  output logic                    out_last_of_run,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_PREP1, ST_PREP2, ST_PREP3, ST_RUN
  } state_t;

  // configuration
  logic [4:0]  cpg_r;
  logic [3:0]  grp_r;
  logic [12:0] len_r;
  logic [6:0]  dt_r;
  logic [5:0]  st_r;
  logic        bias_en_r;
  logic [2:0]  reg_idx;
  logic        cfg_wr;
  logic [7:0]  tot_dt_chk;
  logic [7:0]  tot_st_chk;
  logic [6:0]  total;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign total   = 7'(dt_r + {st_r, 1'b0});
  assign tot_dt_chk = 8'(pwdata[6:0]) + {1'b0, st_r, 1'b0};
  assign tot_st_chk = 8'(dt_r) + {1'b0, pwdata[5:0], 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cpg_r     <= 5'd1;
      grp_r     <= 4'd1;
      len_r     <= 13'd1;
      dt_r      <= 7'd1;
      st_r      <= 6'd0;
      bias_en_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_CPG: if (pwdata >= 32'd1 && pwdata <= 32'(MAX_CIN)) cpg_r <= pwdata[4:0];
        REG_GRP: if (pwdata >= 32'd1 && pwdata <= 32'(MAX_GROUPS)) grp_r <= pwdata[3:0];
        REG_LEN: if (pwdata >= 32'd1 && pwdata <= 32'(MAX_LENGTH)) len_r <= pwdata[12:0];
        REG_DT: begin
          if (pwdata <= 32'd64 && tot_dt_chk >= 8'd1 && tot_dt_chk <= 8'(MAX_COUT)) begin
            dt_r <= pwdata[6:0];
          end
        end
        REG_ST: begin
          if (pwdata <= 32'd32 && tot_st_chk >= 8'd1 && tot_st_chk <= 8'(MAX_COUT)) begin
            st_r <= pwdata[5:0];
          end
        end
        REG_BIAS: if (pwdata <= 32'd1) bias_en_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_CPG:  prdata = 32'(cpg_r);
      REG_GRP:  prdata = 32'(grp_r);
      REG_LEN:  prdata = 32'(len_r);
      REG_DT:   prdata = 32'(dt_r);
      REG_ST:   prdata = 32'(st_r);
      REG_BIAS: prdata = 32'(bias_en_r);
      default:  prdata = 32'd0;
    endcase
  end

  // control
  state_t      state_r, state_nxt;
  logic [2:0]  g_r, g_nxt;
  logic [11:0] pos_r, pos_nxt;
  logic [3:0]  i_r, i_nxt;
  logic [5:0]  o_r, o_nxt;
  logic        wait_r, wait_nxt;
  logic [WADDR_W-1:0] waddr_r, waddr_nxt;
  logic [BADDR_W-1:0] baddr_r, baddr_nxt;
  logic [8:0]  gt_r, gt_nxt;
  logic [DST_W-1:0] rl_r, rl_nxt, nl_r, nl_nxt;
  logic [DST_W-1:0] grl_r, grl_nxt, krl_r, krl_nxt, gnl_r, gnl_nxt, knl_r, knl_nxt;
  logic [DST_W-1:0] dst_r, dst_nxt;
  logic [1:0]  sec_r, sec_nxt;
  logic        outv_r;

  logic in_xfer, out_xfer, sample_ok, trigger, issue, i_last, o_last;
  logic [6:0] o_inc;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = outv_r && !out_stall;
  assign sample_ok = (in_operation == OP_SAMPLE) && ({1'b0, in_group_index} < grp_r)
                     && ({1'b0, in_channel_index} < cpg_r) && ({1'b0, in_position} < len_r);
  assign trigger   = in_xfer && sample_ok && (5'(in_channel_index) + 5'd1 == cpg_r);
  assign issue     = (state_r == ST_RUN) && !wait_r;
  assign i_last    = (5'(i_r) + 5'd1 == cpg_r);
  assign o_inc     = 7'(o_r) + 7'd1;
  assign o_last    = (o_inc == total);

  always_comb begin
    state_nxt = state_r;
    g_nxt     = g_r;
    pos_nxt   = pos_r;
    i_nxt     = i_r;
    o_nxt     = o_r;
    wait_nxt  = wait_r;
    waddr_nxt = waddr_r;
    baddr_nxt = baddr_r;
    gt_nxt    = gt_r;
    rl_nxt    = rl_r;
    nl_nxt    = nl_r;
    grl_nxt   = grl_r;
    krl_nxt   = krl_r;
    gnl_nxt   = gnl_r;
    knl_nxt   = knl_r;
    dst_nxt   = dst_r;
    sec_nxt   = sec_r;
    unique case (state_r)
      ST_IDLE: begin
        if (trigger) begin
          state_nxt = ST_PREP1;
          g_nxt     = in_group_index;
          pos_nxt   = in_position;
        end
      end
      ST_PREP1: begin
        gt_nxt    = 9'(g_r * total);
        rl_nxt    = DST_W'(dt_r * len_r);
        nl_nxt    = DST_W'(st_r * len_r);
        state_nxt = ST_PREP2;
      end
      ST_PREP2: begin
        waddr_nxt = WADDR_W'(gt_r * cpg_r);
        baddr_nxt = gt_r;
        grl_nxt   = DST_W'(g_r * rl_r);
        krl_nxt   = DST_W'(grp_r * rl_r);
        gnl_nxt   = DST_W'(g_r * nl_r);
        knl_nxt   = DST_W'(grp_r * nl_r);
        state_nxt = ST_PREP3;
      end
      ST_PREP3: begin
        o_nxt    = '0;
        i_nxt    = '0;
        wait_nxt = 1'b0;
        if (dt_r == 7'd0) begin
          sec_nxt = SEC_B;
          dst_nxt = gnl_r + DST_W'(pos_r);
        end else begin
          sec_nxt = SEC_DT;
          dst_nxt = grl_r + DST_W'(pos_r);
        end
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (issue) begin
          waddr_nxt = waddr_r + 1'b1;
          if (i_last) begin
            i_nxt    = '0;
            wait_nxt = 1'b1;
          end else begin
            i_nxt = i_r + 1'b1;
          end
        end
        if (out_xfer) begin
          wait_nxt  = 1'b0;
          baddr_nxt = baddr_r + 1'b1;
          o_nxt     = o_inc[5:0];
          if (o_last) begin
            state_nxt = ST_IDLE;
          end else if (o_inc == dt_r) begin
            sec_nxt = SEC_B;
            dst_nxt = krl_r + gnl_r + DST_W'(pos_r);
          end else if (o_inc == dt_r + 7'(st_r)) begin
            sec_nxt = SEC_C;
            dst_nxt = krl_r + knl_r + gnl_r + DST_W'(pos_r);
          end else begin
            dst_nxt = dst_r + DST_W'(len_r);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      wait_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      wait_r  <= wait_nxt;
    end
    g_r     <= g_nxt;
    pos_r   <= pos_nxt;
    i_r     <= i_nxt;
    o_r     <= o_nxt;
    waddr_r <= waddr_nxt;
    baddr_r <= baddr_nxt;
    gt_r    <= gt_nxt;
    rl_r    <= rl_nxt;
    nl_r    <= nl_nxt;
    grl_r   <= grl_nxt;
    krl_r   <= krl_nxt;
    gnl_r   <= gnl_nxt;
    knl_r   <= knl_nxt;
    dst_r   <= dst_nxt;
    sec_r   <= sec_nxt;
  end

  // memories
  logic signed [15:0] wmem [WEIGHT_DEPTH];
  logic signed [31:0] bmem [BIAS_DEPTH];
  logic signed [15:0] wd_r;
  logic signed [31:0] bd_r;

  always_ff @(posedge clk) begin
    if (in_xfer && in_operation == OP_WEIGHT) begin
      wmem[in_table_address] <= in_table_value[15:0];
    end
    if (issue) begin
      wd_r <= wmem[waddr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && in_operation == OP_BIAS && in_table_address[12:BADDR_W] == '0) begin
      bmem[in_table_address[BADDR_W-1:0]] <= in_table_value;
    end
    if (issue) begin
      bd_r <= bmem[baddr_r];
    end
  end

  // activation chain: rotates over channels_per_group cells on each issue
  logic signed [15:0] cell_q   [MAX_CIN];
  logic signed [15:0] cell_nbr [MAX_CIN];

  for (genvar j = 0; j < MAX_CIN; j++) begin : g_cells
    assign cell_nbr[j] = (5'(j + 1) >= cpg_r) ? cell_q[0] : cell_q[(j + 1) % MAX_CIN];
    gpc_cell u_cell (
      .clk       (clk),
      .load      (in_xfer && sample_ok && in_channel_index == 4'(j)),
      .load_data (in_sample_value),
      .shift     (issue),
      .nbr_data  (cell_nbr[j]),
      .data      (cell_q[j])
    );
  end

  // MAC pipeline
  logic               s1_v_r, s1_first_r, s1_last_r;
  logic               s2_v_r, s2_first_r, s2_last_r;
  logic signed [15:0] act_r;
  logic signed [31:0] prod_r, bias2_r;
  logic signed [ACC_W-1:0] acc_r, acc_base, acc_sum;
  logic signed [31:0] res_r;

  always_comb begin
    if (!s2_first_r) begin
      acc_base = acc_r;
    end else if (bias_en_r) begin
      acc_base = ACC_W'(bias2_r);
    end else begin
      acc_base = '0;
    end
    acc_sum = acc_base + ACC_W'(prod_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      outv_r <= 1'b0;
    end else begin
      s1_v_r <= issue;
      s2_v_r <= s1_v_r;
      if (s2_v_r && s2_last_r) begin
        outv_r <= 1'b1;
      end else if (out_xfer) begin
        outv_r <= 1'b0;
      end
    end
    s1_first_r <= (i_r == '0);
    s1_last_r  <= i_last;
    act_r      <= cell_q[0];
    s2_first_r <= s1_first_r;
    s2_last_r  <= s1_last_r;
    prod_r     <= act_r * wd_r;
    bias2_r    <= bd_r;
    if (s2_v_r) begin
      acc_r <= acc_sum;
    end
    if (s2_v_r && s2_last_r) begin
      res_r <= sat32(acc_sum);
    end
  end

  assign out_valid             = outv_r;
  assign out_result_value      = res_r;
  assign out_destination_index = dst_r;
  assign out_section           = sec_r;
  assign out_last_of_run       = o_last;

  `GPC_ASSERT(a_out_in_run, outv_r |-> (state_r == ST_RUN && wait_r), "result outside a run")
  `GPC_ASSERT(a_no_issue_busy, issue |-> !outv_r, "issue while result pending")
  `GPC_ASSERT(a_result_held, (outv_r && out_stall) |=> outv_r && $stable(res_r), "result lost")
  `GPC_ASSERT(a_run_ends, (out_xfer && o_last) |=> state_r == ST_IDLE, "run did not end")

endmodule

`default_nettype wire

// ===== tb/sv/grouped_pointwise_conv1d_split_out_checker.sv =====
// Checker for the grouped pointwise convolution: mirrors the register file and
// tables, predicts every result of an accepted item and compares the result stream.
// Depends on gpc_pkg.
`timescale 1ns / 1ps

module grouped_pointwise_conv1d_split_out_checker
  import gpc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic [1:0]         in_operation,
  input  wire logic [12:0]        in_table_address,
  input  wire logic signed [31:0] in_table_value,
  input  wire logic [2:0]         in_group_index,
  input  wire logic [3:0]         in_channel_index,
  input  wire logic [11:0]        in_position,
  input  wire logic signed [15:0] in_sample_value,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic signed [31:0] out_result_value,
  input  wire logic [20:0]        out_destination_index,
  input  wire logic [1:0]         out_section,
  input  wire logic               out_last_of_run,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  input  wire logic               pready,
  output int                      failures,
  output int                      pending
);

  typedef struct packed {
    logic signed [31:0] value;
    logic [20:0]        dest;
    logic [1:0]         sec;
    logic               last;
  } conv_result_t;

  conv_result_t expected_results[$];

  logic signed [15:0] weight_mem [WEIGHT_DEPTH];
  logic signed [31:0] bias_mem [BIAS_DEPTH];
  logic signed [15:0] act_buf [MAX_CIN];

  int unsigned cpg, grp, seq_len, dt_cnt, st_cnt, bias_on;

  initial begin
    failures = 0;
    for (int i = 0; i < WEIGHT_DEPTH; i++) weight_mem[i] = '0;
    for (int i = 0; i < BIAS_DEPTH; i++) bias_mem[i] = '0;
    for (int i = 0; i < MAX_CIN; i++) act_buf[i] = '0;
  end

  assign pending = expected_results.size();

  function automatic bit outs_legal(int unsigned r, int unsigned n);
    return (r + 2 * n >= 1) && (r + 2 * n <= MAX_COUT);
  endfunction

  function automatic void write_reg(logic [2:0] idx, logic [31:0] v);
    case (idx)
      REG_CPG:  if (v >= 1 && v <= MAX_CIN) cpg = v;
      REG_GRP:  if (v >= 1 && v <= MAX_GROUPS) grp = v;
      REG_LEN:  if (v >= 1 && v <= MAX_LENGTH) seq_len = v;
      REG_DT:   if (v <= 64 && outs_legal(v, st_cnt)) dt_cnt = v;
      REG_ST:   if (v <= 32 && outs_legal(dt_cnt, v)) st_cnt = v;
      REG_BIAS: if (v <= 1) bias_on = v;
      default: ;
    endcase
  endfunction

  // Apply one accepted input item and queue the dot products it triggers.
  function automatic void conv_step();
    int unsigned g, ch, pos, total, go, wi, dst;
    logic signed [63:0] acc;
    logic signed [31:0] prod;
    conv_result_t res;
    g = in_group_index;
    ch = in_channel_index;
    pos = in_position;
    total = dt_cnt + 2 * st_cnt;
    case (in_operation)
      OP_WEIGHT: weight_mem[in_table_address] = in_table_value[15:0];
      OP_BIAS:   if (in_table_address < BIAS_DEPTH) bias_mem[in_table_address] = in_table_value;
      OP_SAMPLE: begin
        if (g < grp && ch < cpg && pos < seq_len) begin
          act_buf[ch] = in_sample_value;
          if (ch + 1 == cpg) begin
            for (int unsigned o = 0; o < total; o++) begin
              go = g * total + o;
              acc = '0;
              if (bias_on != 0 && go < BIAS_DEPTH) acc = bias_mem[go];
              for (int unsigned i = 0; i < cpg; i++) begin
                wi = go * cpg + i;
                prod = act_buf[i] * weight_mem[wi];
                acc += prod;
              end
              if (acc > 64'sh7FFF_FFFF) acc = 64'sh7FFF_FFFF;
              if (acc < -64'sh8000_0000) acc = -64'sh8000_0000;
              if (o < dt_cnt) begin
                res.sec = SEC_DT;
                dst = (g * dt_cnt + o) * seq_len + pos;
              end else if (o < dt_cnt + st_cnt) begin
                res.sec = SEC_B;
                dst = grp * dt_cnt * seq_len + (g * st_cnt + (o - dt_cnt)) * seq_len + pos;
              end else begin
                res.sec = SEC_C;
                dst = grp * (dt_cnt + st_cnt) * seq_len
                    + (g * st_cnt + (o - dt_cnt - st_cnt)) * seq_len + pos;
              end
              res.value = acc[31:0];
              res.dest = dst[20:0];
              res.last = (o + 1 == total);
              expected_results.push_back(res);
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    conv_result_t exp_r;
    if (!rst_n) begin
      cpg = 1; grp = 1; seq_len = 1; dt_cnt = 1; st_cnt = 0; bias_on = 0;
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("unexpected result transfer: value %h dest %0d sec %0d last %0b",
                     out_result_value, out_destination_index, out_section, out_last_of_run);
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r.value !== out_result_value || exp_r.dest !== out_destination_index ||
              exp_r.sec !== out_section || exp_r.last !== out_last_of_run) begin
            failures++;
            if (failures <= 10)
              $display("mismatch: exp %h dest %0d sec %0d last %0b, got %h %0d %0d %0b",
                       exp_r.value, exp_r.dest, exp_r.sec, exp_r.last, out_result_value,
                       out_destination_index, out_section, out_last_of_run);
          end
        end
      end
      if (psel && penable && pwrite && pready) write_reg(paddr[4:2], pwdata);
      if (in_valid && !in_stall) conv_step();
    end
  end

endmodule

// ===== tb/sv/grouped_pointwise_conv1d_split_out_test.sv =====
// Top of the grouped pointwise convolution test: clock, reset, register setup,
// table loading, directed and random activation traffic, and the verdict.
// Depends on gpc_pkg, the block and grouped_pointwise_conv1d_split_out_checker.
`timescale 1ns / 1ps

module grouped_pointwise_conv1d_split_out_test
  import gpc_pkg::*;
();

  // register slots past the last register
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         in_operation;
  logic [12:0]        in_table_address;
  logic signed [31:0] in_table_value;
  logic [2:0]         in_group_index;
  logic [3:0]         in_channel_index;
  logic [11:0]        in_position;
  logic signed [15:0] in_sample_value;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_result_value;
  logic [20:0]        out_destination_index;
  logic [1:0]         out_section;
  logic               out_last_of_run;
  logic               psel, penable, pwrite, pready;
  logic [4:0]         paddr;
  logic [31:0]        pwdata, prdata;
  int                 failures, pending;

  bit calm;
  int hold_seq, hold_len;
  int unsigned cur_cpg, cur_grp, cur_len;

  grouped_pointwise_conv1d_split_out DUT (.*);

  grouped_pointwise_conv1d_split_out_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  initial begin
    int seen, left;
    seen = 0;
    left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seq != seen) begin
        seen = hold_seq;
        left = hold_len;
      end
      if (left > 0) begin
        left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 32);
      end
    end
  end

  task automatic send(logic [1:0] op, int unsigned addr, int unsigned tval, int unsigned g,
                      int unsigned ch, int unsigned pos, int unsigned smp);
    int unsigned gap;
    @(negedge clk);
    gap = 0;
    if (!calm && $urandom_range(99) < 32) gap = $urandom_range(3);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_table_address <= 13'(addr);
    in_table_value <= tval;
    in_group_index <= 3'(g);
    in_channel_index <= 4'(ch);
    in_position <= 12'(pos);
    in_sample_value <= 16'(smp);
    do @(posedge clk); while (in_stall);
  endtask

  task automatic go_quiet();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] v);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(7))
      0: return 16'h7FFF;
      1: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // One well-formed activation vector; optionally shuffle all but the last channel.
  task automatic send_vector(int unsigned g, int unsigned pos, bit shuffle, bit fixed_smp,
                             logic [15:0] smp);
    int unsigned order[$];
    for (int unsigned c = 0; c + 1 < cur_cpg; c++) order.push_back(c);
    if (shuffle) order.shuffle();
    order.push_back(cur_cpg - 1);
    foreach (order[k])
      send(OP_SAMPLE, $urandom, $urandom, g, order[k], pos,
           fixed_smp ? smp : pick_sample());
  endtask

  // Load every weight and bias that the current setup reads.
  task automatic load_tables(int unsigned n_weights, int unsigned n_biases);
    logic [31:0] tv;
    for (int unsigned a = 0; a < n_weights; a++) begin
      tv = $urandom;
      if (a % 5 == 0) tv[15:0] = 16'h7FFF;
      if (a % 7 == 0) tv[15:0] = 16'h8000;
      send(OP_WEIGHT, a, tv, $urandom, $urandom, $urandom, $urandom);
    end
    for (int unsigned a = 0; a < n_biases; a++) begin
      case ($urandom_range(3))
        0: tv = 32'h7FFF_FFFF;
        1: tv = 32'h8000_0000;
        default: tv = $urandom;
      endcase
      send(OP_BIAS, a, tv, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  task automatic send_noise();
    case ($urandom_range(4))
      0: send(OP_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      1: send(OP_WEIGHT, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      2: send(OP_BIAS, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      default: begin
        if (cur_grp < MAX_GROUPS)
          send(OP_SAMPLE, $urandom, $urandom, $urandom_range(7, cur_grp), $urandom,
               $urandom, $urandom);
        else if (cur_cpg < MAX_CIN)
          send(OP_SAMPLE, $urandom, $urandom, $urandom, $urandom_range(15, cur_cpg),
               $urandom, $urandom);
        else if (cur_len < MAX_LENGTH)
          send(OP_SAMPLE, $urandom, $urandom, $urandom, $urandom,
               $urandom_range(4095, cur_len), $urandom);
        else
          send(OP_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
    endcase
  endtask

  task automatic set_phase(int unsigned cpg, int unsigned grp, int unsigned len,
                           int unsigned r, int unsigned n, int unsigned bias);
    reg_write(REG_CPG, cpg);
    reg_write(REG_GRP, grp);
    reg_write(REG_LEN, len);
    // walk through legal output counts so the target pair is reachable
    reg_write(REG_ST, 1);
    reg_write(REG_DT, 1);
    reg_write(REG_ST, 0);
    reg_write(REG_ST, 1);
    reg_write(REG_DT, r);
    reg_write(REG_ST, n);
    reg_write(REG_DT, r);
    reg_write(REG_BIAS, bias);
    cur_cpg = cpg;
    cur_grp = grp;
    cur_len = len;
  endtask

  task automatic random_traffic(int n_items);
    int sent;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 70) begin
        send_vector($urandom_range(cur_grp - 1), $urandom_range(cur_len - 1),
                    $urandom_range(3) == 0, 1'b0, '0);
        sent += cur_cpg;
      end else begin
        send_noise();
        sent++;
      end
    end
  endtask

  int unsigned ph_cpg[5]   = '{2, 1, 3, 16, 1};
  int unsigned ph_grp[5]   = '{2, 8, 3, 1, 1};
  int unsigned ph_len[5]   = '{4096, 4096, 5, 7, 2};
  int unsigned ph_dt[5]    = '{2, 1, 0, 1, 0};
  int unsigned ph_st[5]    = '{1, 0, 1, 0, 32};
  int unsigned ph_bias[5]  = '{1, 0, 1, 0, 0};
  int          ph_items[5] = '{20, 10, 20, 32, 16};

  initial begin
    int unsigned outs;
    calm = 1'b0;
    hold_seq = 0;
    hold_len = 0;
    cur_cpg = 1; cur_grp = 1; cur_len = 1;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_operation = OP_WEIGHT;
    in_table_address = '0;
    in_table_value = '0;
    in_group_index = '0;
    in_channel_index = '0;
    in_position = '0;
    in_sample_value = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int p = 0; p < 5; p++) begin
      if (p == 2) begin
        // refused values and unused register slots
        reg_write(REG_CPG, 0);
        reg_write(REG_CPG, 17);
        reg_write(REG_GRP, 0);
        reg_write(REG_GRP, 9);
        reg_write(REG_LEN, 0);
        reg_write(REG_LEN, 4097);
        reg_write(REG_DT, 65);
        reg_write(REG_ST, 33);
        reg_write(REG_BIAS, 2);
        reg_write(REG_SPARE_LO, 1);
        reg_write(REG_SPARE_HI, 1);
      end
      set_phase(ph_cpg[p], ph_grp[p], ph_len[p], ph_dt[p], ph_st[p], ph_bias[p]);
      @(posedge clk);
      calm = (p == 3);
      outs = ph_grp[p] * (ph_dt[p] + 2 * ph_st[p]);
      load_tables(outs * ph_cpg[p], (ph_bias[p] != 0) ? outs : 0);
      case (p)
        0: begin
          // full vectors at the corners of the index space
          send_vector(0, 0, 1'b0, 1'b1, 16'h7FFF);
          send_vector(1, 4095, 1'b0, 1'b1, 16'h8000);
          send(OP_UNUSED, '1, '1, '1, '1, '1, '1);
        end
        1: begin
          // hold the receiver off while the sender keeps going
          @(posedge clk);
          hold_len = 400;
          hold_seq++;
          calm = 1'b1;
          send_vector(7, 4095, 1'b0, 1'b0, '0);
          for (int k = 0; k < 19; k++)
            send_vector($urandom_range(7), $urandom_range(4095), 1'b0, 1'b0, '0);
          go_quiet();
          calm = 1'b0;
        end
        2: begin
          send(OP_SAMPLE, 0, 0, 7, 0, 0, 16'h1234);
          send(OP_SAMPLE, 0, 0, 0, 15, 0, 16'h1234);
          send(OP_SAMPLE, 0, 0, 0, 2, 4095, 16'h1234);
          send(OP_BIAS, 13'h1FFF, 32'h7FFF_FFFF, 0, 0, 0, 0);
          send_vector(2, 4, 1'b0, 1'b0, '0);
          // last channel alone reuses the buffered channels
          send(OP_SAMPLE, 0, 0, 1, 2, 3, 16'h8000);
        end
        default: ;
      endcase
      random_traffic(ph_items[p]);
      go_quiet();
      calm = 1'b0;
    end

    if (failures == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
